### design/cbc_pkg.sv
// shared types, constants and helpers for the cartridge bank controller
package cbc_pkg;

    localparam int MAX_ROM_BANKS_DEF    = 512;
    localparam int MAX_RAM_BANKS_DEF    = 16;
    localparam int NIBBLE_RAM_DEPTH_DEF = 512;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [1:0] TGT_ROM = 2'd0;
    localparam logic [1:0] TGT_RAM = 2'd1;
    localparam logic [1:0] TGT_INT = 2'd2;

    localparam logic [1:0] CFG_KIND  = 2'd0;
    localparam logic [1:0] CFG_RSIZE = 2'd1;
    localparam logic [1:0] CFG_RBCNT = 2'd2;

    // one queued item handed from front to back
    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] bus_address;
        logic [7:0]  write_value;
    } t_item;

    // controller kind decode
    typedef struct packed {
        logic k1;
        logic k2;
        logic k3;
        logic k5;
        logic batt;
    } t_kind;

    function automatic t_kind decode_kind(input logic [7:0] c);
        t_kind k;
        k.k1   = (c >= 8'h01) && (c <= 8'h03);
        k.k2   = (c == 8'h05) || (c == 8'h06);
        k.k3   = (c >= 8'h0F) && (c <= 8'h13);
        k.k5   = (c >= 8'h19) && (c <= 8'h1E);
        k.batt = (c == 8'h03) || (c == 8'h06) || (c == 8'h0F) || (c == 8'h10) ||
                 (c == 8'h13) || (c == 8'h1B) || (c == 8'h1E);
        return k;
    endfunction

endpackage

### design/cbc_front.sv
// front end: input skid queue of two items
module cbc_front
    import cbc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    logic [1:0] r_count;
    logic       r_wptr, r_rptr;
    t_item      r_q [2];
    logic       push, pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_q[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
        end else begin
            if (push) r_wptr <= ~r_wptr;
            if (pop) r_rptr <= ~r_rptr;
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wptr] <= i_item;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("queue count overflow");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 2'd1) else $error("push lost");
    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_count == $past(r_count) - 2'd1) else $error("pop lost");
endmodule

### design/cbc_back.sv
// back end: bank state, clock, nibble ram, serial modulo and result register
module cbc_back
    import cbc_pkg::*;
#(
    parameter int MAX_ROM_BANKS    = MAX_ROM_BANKS_DEF,
    parameter int MAX_RAM_BANKS    = MAX_RAM_BANKS_DEF,
    parameter int NIBBLE_RAM_DEPTH = NIBBLE_RAM_DEPTH_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    input  logic [7:0]  i_kind_code,
    input  logic [2:0]  i_ram_size,
    input  logic [9:0]  i_bank_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_target,
    output logic [22:0] o_phys_address,
    output logic [7:0]  o_read_data,
    output logic        o_save_needed
);
    localparam int NA = $clog2(NIBBLE_RAM_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_NIB  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_TICK = 3'd5;

    logic [2:0]  r_state;
    t_item       r_it;
    logic        r_ram_enable;
    logic [4:0]  r_low;
    logic [1:0]  r_high;
    logic [8:0]  r_rom_sel;
    logic [7:0]  r_ram_sel;
    logic        r_mode;
    logic [7:0]  r_clk [5];
    logic [7:0]  r_lat [5];
    logic        r_armed;
    logic        r_dirty;
    logic [3:0]  r_nib [NIBBLE_RAM_DEPTH];
    logic [3:0]  r_nib_q;
    logic        r_clr;
    logic [NA-1:0] r_clr_addr;
    // serial remainder
    logic [9:0]  r_rem;
    logic [3:0]  r_bit;
    logic [8:0]  r_dividend;
    logic        r_use_rem;
    logic [1:0]  r_tgt;
    logic [22:0] r_phys;
    logic [7:0]  r_data;
    logic [2:0]  r_hcarry;
    logic        r_ovalid;
    logic [1:0]  r_o_tgt;
    logic [22:0] r_o_phys;
    logic [7:0]  r_o_data;
    logic        r_o_save;

    t_kind       k;
    logic        mapped, ram_win;
    logic [9:0]  total;
    logic [15:0] a;
    logic [7:0]  v;
    logic [3:0]  rmask;
    logic        ram_ok;
    logic [7:0]  ext_idx;
    logic        ext_ok;
    logic [10:0] trial;
    logic [NA-1:0] nib_addr;
    logic        is_clk_sel;

    logic [1:0]  e_tgt;
    logic [22:0] e_phys;
    logic [7:0]  e_data;
    logic [2:0]  e_next;
    logic        e_use_rem;
    logic [8:0]  e_dividend;

    logic [8:0]  t_s1, t_m1, t_h1;
    logic [2:0]  t_qs, t_qm;
    logic [3:0]  t_qh;
    logic [7:0]  t_s, t_m, t_h;
    logic [9:0]  t_dd;

    assign k       = decode_kind(i_kind_code);
    assign mapped  = k.k1 | k.k2 | k.k3 | k.k5;
    assign a       = r_it.bus_address;
    assign v       = r_it.write_value;
    assign ram_win = (a & 16'hE000) == 16'hA000;
    assign nib_addr = a[NA-1:0];
    assign is_clk_sel = k.k3 && r_ram_sel >= 8'h08 && r_ram_sel <= 8'h0C;

    always_comb begin
        total = i_bank_count;
        if (total == 10'd0) total = 10'd1;
        if (total > 10'(MAX_ROM_BANKS)) total = 10'(MAX_ROM_BANKS);
        unique case (i_ram_size)
            3'd3:    rmask = 4'h3;
            3'd4:    rmask = 4'hF;
            3'd5:    rmask = 4'h7;
            default: rmask = 4'h0;
        endcase
        ram_ok  = (i_ram_size >= 3'd2) && (i_ram_size <= 3'd5);
        if (k.k1) ext_idx = r_mode ? (r_ram_sel & {4'h0, rmask}) : 8'h00;
        else      ext_idx = r_ram_sel & {4'h0, rmask};
        ext_ok  = ram_ok && (ext_idx < 8'(MAX_RAM_BANKS)) &&
                  (!k.k3 || r_ram_sel <= 8'h03);
        trial   = {r_rem, r_dividend[r_bit]} - {1'b0, total};
    end

    // answer and next step for the item in hand
    always_comb begin
        e_tgt      = TGT_INT;
        e_phys     = '0;
        e_data     = 8'hFF;
        e_next     = S_OUT;
        e_use_rem  = 1'b0;
        e_dividend = '0;
        if (r_it.req_type == REQ_READ) begin
            if (a < 16'h8000) begin
                e_tgt = TGT_ROM;
                if (a < 16'h4000) begin
                    if (k.k1 && r_mode) begin
                        e_dividend = {2'b0, r_high, 5'd0};
                        e_use_rem  = 1'b1;
                    end else e_phys = {7'd0, a};
                end else if (mapped) begin
                    if (k.k1) e_dividend = {2'b0, r_high, r_low};
                    else if (k.k2) e_dividend = {5'd0, r_rom_sel[3:0]};
                    else if (k.k3) e_dividend = {2'd0, r_rom_sel[6:0]};
                    else e_dividend = r_rom_sel;
                    e_use_rem = 1'b1;
                end else e_phys = {7'd0, a};
                if (e_use_rem) e_next = S_MOD;
            end else if (ram_win && r_ram_enable && mapped) begin
                if (k.k2) e_next = S_NIB;
                else if (is_clk_sel) e_data = r_lat[r_ram_sel[2:0]];
                else if (ext_ok) begin
                    e_tgt  = TGT_RAM;
                    e_phys = {2'd0, ext_idx, a[12:0]};
                end
            end
        end else if (r_it.req_type == REQ_WRITE && mapped) begin
            if (ram_win && r_ram_enable && !k.k2 && !is_clk_sel && ext_ok) begin
                e_tgt  = TGT_RAM;
                e_phys = {2'd0, ext_idx, a[12:0]};
            end
        end else if (r_it.req_type == REQ_TICK && !r_clk[4][6]) begin
            e_next = S_TICK;
        end
    end

    assign o_ready        = (r_state == S_IDLE) && !r_clr;
    assign o_valid        = r_ovalid;
    assign o_target       = r_o_tgt;
    assign o_phys_address = r_o_phys;
    assign o_read_data    = r_o_data;
    assign o_save_needed  = r_o_save;

    // tick arithmetic: seconds and minutes first, then hours and days
    always_comb begin
        t_s1 = {1'b0, r_clk[0]} + 9'd1;
        t_qs = 3'd0;
        for (int q = 1; q <= 4; q++) if (t_s1 >= 9'(60 * q)) t_qs = 3'(q);
        t_s  = 8'(t_s1 - 9'(t_qs) * 9'd60);
        t_m1 = {1'b0, r_clk[1]} + 9'(t_qs);
        t_qm = 3'd0;
        for (int q = 1; q <= 4; q++) if (t_m1 >= 9'(60 * q)) t_qm = 3'(q);
        t_m  = 8'(t_m1 - 9'(t_qm) * 9'd60);
        t_h1 = {1'b0, r_clk[2]} + 9'(r_hcarry);
        t_qh = 4'd0;
        for (int q = 1; q <= 10; q++) if (t_h1 >= 9'(24 * q)) t_qh = 4'(q);
        t_h  = 8'(t_h1 - 9'(t_qh) * 9'd24);
        t_dd = {1'b0, r_clk[4][0], r_clk[3]} + 10'(t_qh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ovalid     <= 1'b0;
            r_o_tgt      <= TGT_INT;
            r_o_phys     <= '0;
            r_o_data     <= 8'hFF;
            r_o_save     <= 1'b0;
            r_ram_enable <= 1'b0;
            r_low        <= 5'd1;
            r_high       <= 2'd0;
            r_rom_sel    <= 9'd1;
            r_ram_sel    <= 8'd0;
            r_mode       <= 1'b0;
            r_armed      <= 1'b0;
            r_dirty      <= 1'b0;
            r_clr        <= 1'b1;
            r_clr_addr   <= '0;
            for (int i = 0; i < 5; i++) begin
                r_clk[i] <= 8'd0;
                r_lat[i] <= 8'd0;
            end
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + NA'(1);
                if (r_clr_addr == NA'(NIBBLE_RAM_DEPTH - 1)) r_clr <= 1'b0;
            end
            if (r_state == S_OUT && (!r_ovalid || i_ready)) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && !r_clr) begin
                    r_it    <= i_item;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_tgt      <= e_tgt;
                    r_phys     <= e_phys;
                    r_data     <= e_data;
                    r_state    <= e_next;
                    r_use_rem  <= e_use_rem;
                    r_dividend <= e_dividend;
                    r_rem      <= '0;
                    r_bit      <= 4'd8;
                    if (r_it.req_type == REQ_WRITE && mapped) begin
                        if (a < 16'h2000) begin
                            if (!k.k2 || !a[8]) r_ram_enable <= (v[3:0] == 4'hA);
                        end else if (a < 16'h4000) begin
                            if (k.k1) r_low <= (v[4:0] != 5'd0) ? v[4:0] : 5'd1;
                            else if (k.k2) begin
                                if (a[8])
                                    r_rom_sel <= (v[3:0] != 4'd0) ? {5'd0, v[3:0]} : 9'd1;
                            end else if (k.k3)
                                r_rom_sel <= (v[6:0] != 7'd0) ? {2'd0, v[6:0]} : 9'd1;
                            else if (a < 16'h3000) r_rom_sel <= {r_rom_sel[8], v};
                            else r_rom_sel <= {v[0], r_rom_sel[7:0]};
                        end else if (a < 16'h6000) begin
                            if (k.k1) begin
                                r_high <= v[1:0]; r_ram_sel <= {6'd0, v[1:0]};
                            end else if (k.k3) r_ram_sel <= v;
                            else if (k.k5) r_ram_sel <= {4'd0, v[3:0]};
                        end else if (a < 16'h8000) begin
                            if (k.k1) r_mode <= v[0];
                            else if (k.k3) begin
                                if (!r_armed && v == 8'd1)
                                    for (int i = 0; i < 5; i++) r_lat[i] <= r_clk[i];
                                r_armed <= (v == 8'd1);
                            end
                        end else if (ram_win && r_ram_enable) begin
                            if (k.k2) begin
                                if (k.batt) r_dirty <= 1'b1;
                            end else if (is_clk_sel) r_clk[r_ram_sel[2:0]] <= v;
                            else if (ext_ok && k.batt) r_dirty <= 1'b1;
                        end
                    end else if (r_it.req_type == REQ_TICK && !r_clk[4][6]) begin
                        r_clk[0] <= t_s;
                        r_clk[1] <= t_m;
                        r_hcarry <= t_qm;
                    end
                end
                S_MOD: begin
                    // restoring remainder, one dividend bit a cycle
                    r_rem <= trial[10] ? {r_rem[8:0], r_dividend[r_bit]} : trial[9:0];
                    if (r_bit == 4'd0) r_state <= S_OUT;
                    else r_bit <= r_bit - 4'd1;
                end
                S_NIB: begin
                    r_data  <= {4'hF, r_nib_q};
                    r_state <= S_OUT;
                end
                S_TICK: begin
                    r_clk[2] <= t_h;
                    r_clk[3] <= t_dd[7:0];
                    r_clk[4] <= (r_clk[4] & 8'hFE) | {7'd0, t_dd[8]} |
                                (t_dd[9] ? 8'h80 : 8'h00);
                    r_state  <= S_OUT;
                end
                S_OUT: if (!r_ovalid || i_ready) begin
                    r_o_tgt  <= r_tgt;
                    r_o_phys <= r_use_rem ? {r_rem[8:0], a[13:0]} : r_phys;
                    r_o_data <= r_data;
                    r_o_save <= r_dirty;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // nibble store, zeroed entry by entry after reset
    always_ff @(posedge i_clk) begin
        if (r_clr)
            r_nib[r_clr_addr] <= 4'h0;
        else if (r_state == S_EXEC && r_it.req_type == REQ_WRITE && k.k2 &&
                 ram_win && r_ram_enable)
            r_nib[nib_addr] <= v[3:0];
        r_nib_q <= r_nib[nib_addr];
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_ready) else $error("busy but ready");
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !o_ready) else $error("ready during clear");
    a_dirty_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dirty |=> r_dirty) else $error("dirty flag cleared");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && r_use_rem |-> r_rem < total)
        else $error("remainder out of range");
endmodule

### design/cartridge_bank_controller_top.sv
// top level of the cartridge bank controller
//  channel | direction | handshake                  | payload
//  in      | in        | i_in_valid / o_in_ready    | req_type, bus_address, write_value
//  out     | out       | o_out_valid / i_out_ready  | target, phys_address, read_data, save_needed
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | cfg_index, cfg_data
// the back end takes an item through its idle, exec and output states; a banked rom
// read adds a 9-step serial remainder by the rom bank count
// mbc2 ram reads and ticks of a running clock add a state: a registered memory read, or a
// second stage for hours and days
// after reset the nibble ram is cleared entry by entry before the first item is taken
// a two-entry queue takes items while the back end works; a result not taken holds the
// back end in its output stage
module cartridge_bank_controller_top
    import cbc_pkg::*;
#(
    parameter int MAX_ROM_BANKS    = MAX_ROM_BANKS_DEF,
    parameter int MAX_RAM_BANKS    = MAX_RAM_BANKS_DEF,
    parameter int NIBBLE_RAM_DEPTH = NIBBLE_RAM_DEPTH_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_target,
    output logic [22:0] o_phys_address,
    output logic [7:0]  o_read_data,
    output logic        o_save_needed,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    logic [7:0] r_kind;
    logic [2:0] r_rsize;
    logic [9:0] r_bcnt;
    t_item      in_item, q_item;
    logic       q_valid, q_ready;

    assign o_cfg_ready = 1'b1;
    assign in_item = '{req_type: i_req_type, bus_address: i_bus_address,
                       write_value: i_write_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= 8'd0;
            r_rsize <= 3'd0;
            r_bcnt  <= 10'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KIND:  r_kind  <= i_cfg_data[7:0];
                CFG_RSIZE: r_rsize <= i_cfg_data[2:0];
                CFG_RBCNT: r_bcnt  <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    cbc_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_in_valid), .o_ready(o_in_ready), .i_item(in_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    cbc_back #(
        .MAX_ROM_BANKS(MAX_ROM_BANKS), .MAX_RAM_BANKS(MAX_RAM_BANKS),
        .NIBBLE_RAM_DEPTH(NIBBLE_RAM_DEPTH)
    ) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .i_kind_code(r_kind), .i_ram_size(r_rsize), .i_bank_count(r_bcnt),
        .o_valid(o_out_valid), .i_ready(i_out_ready),
        .o_target, .o_phys_address, .o_read_data, .o_save_needed
    );
endmodule

### tb/cartridge_bank_controller_checker.sv
// checker for the cartridge bank controller: mapping predictor and result scoreboard
module cartridge_bank_controller_checker
    import cbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_target,
    input  logic [22:0] i_phys_address,
    input  logic [7:0]  i_read_data,
    input  logic        i_save_needed,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    output int          o_pending,
    output int          o_failures,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  target;
        logic [22:0] phys_address;
        logic [7:0]  read_data;
        logic        save_needed;
    } bus_answer_t;

    bus_answer_t answer_q[$];

    // configuration copy
    logic [7:0] kind_code;
    logic [2:0] ram_code;
    logic [9:0] bank_count;

    // controller state copy
    logic       ram_on;
    logic [4:0] bank_lo;
    logic [1:0] bank_hi;
    logic [8:0] rom_sel;
    logic [7:0] ram_sel;
    logic       mode;
    logic [3:0] nibbles [512];
    logic [7:0] rtc [5];
    logic [7:0] rtc_latched [5];
    logic       latch_prev_one;
    logic       dirty;

    function automatic int rom_banks();
        int n;
        n = int'(bank_count);
        if (n == 0) n = 1;
        if (n > MAX_ROM_BANKS_DEF) n = MAX_ROM_BANKS_DEF;
        return n;
    endfunction

    function automatic int ram_select_mask();
        case (ram_code)
            3'd3: return 3;
            3'd4: return 15;
            3'd5: return 7;
            default: return 0;
        endcase
    endfunction

    function automatic int switch_bank(t_kind k);
        int b;
        if (k.k1) b = int'({bank_hi, bank_lo});
        else if (k.k2) b = int'(rom_sel & 9'h0F);
        else if (k.k3) b = int'(rom_sel & 9'h7F);
        else b = int'(rom_sel);
        return b % rom_banks();
    endfunction

    // external ram bank, -1 when no ram answers
    function automatic int ext_ram_bank(t_kind k);
        int b;
        if (k.k1) b = mode ? (int'(ram_sel) & ram_select_mask()) : 0;
        else b = int'(ram_sel) & ram_select_mask();
        if (ram_code >= 3'd2 && ram_code <= 3'd5 && b < MAX_RAM_BANKS_DEF) return b;
        return -1;
    endfunction

    task automatic advance_second();
        int s, m, h, d;
        logic [7:0] dh;
        if (rtc[4][6]) return;
        s = int'(rtc[0]) + 1;
        m = int'(rtc[1]) + s / 60;
        s = s % 60;
        h = int'(rtc[2]) + m / 60;
        m = m % 60;
        d = int'({rtc[4][0], rtc[3]}) + h / 24;
        h = h % 24;
        rtc[0] = s[7:0];
        rtc[1] = m[7:0];
        rtc[2] = h[7:0];
        rtc[3] = d[7:0];
        dh = {rtc[4][7:1], d[8]};
        if (d >= 512) dh[7] = 1'b1;
        rtc[4] = dh;
    endtask

    task automatic predict_access(input logic [1:0] req, input logic [15:0] a,
                                  input logic [7:0] v, output bus_answer_t r);
        t_kind k;
        logic  mapped, ram_win;
        int    bank;
        k = decode_kind(kind_code);
        mapped = k.k1 | k.k2 | k.k3 | k.k5;
        ram_win = (a & 16'hE000) == 16'hA000;
        r.target = TGT_INT;
        r.phys_address = '0;
        r.read_data = 8'hFF;
        if (req == REQ_READ) begin
            if (a < 16'h4000) begin
                r.target = TGT_ROM;
                r.phys_address = {7'd0, a};
                if (k.k1 && mode)
                    r.phys_address = 23'(((int'(bank_hi) << 5) % rom_banks()) * 'h4000 +
                                         int'(a));
            end else if (a < 16'h8000) begin
                r.target = TGT_ROM;
                r.phys_address = mapped ? 23'(switch_bank(k) * 'h4000 + int'(a) - 'h4000)
                                        : {7'd0, a};
            end else if (ram_win && ram_on && mapped) begin
                if (k.k2) begin
                    r.read_data = {4'hF, nibbles[a[8:0]]};
                end else if (k.k3 && ram_sel >= 8'h08 && ram_sel <= 8'h0C) begin
                    r.read_data = rtc_latched[ram_sel[2:0]];
                end else if (!k.k3 || ram_sel <= 8'h03) begin
                    bank = ext_ram_bank(k);
                    if (bank >= 0) begin
                        r.target = TGT_RAM;
                        r.phys_address = 23'(bank * 'h2000 + int'(a) - 'hA000);
                    end
                end
            end
        end else if (req == REQ_WRITE && mapped) begin
            if (a < 16'h2000) begin
                if (!k.k2 || !a[8]) ram_on = (v[3:0] == 4'hA);
            end else if (a < 16'h4000) begin
                if (k.k1) bank_lo = (v[4:0] != 5'd0) ? v[4:0] : 5'd1;
                else if (k.k2) begin
                    if (a[8]) rom_sel = (v[3:0] != 4'd0) ? {5'd0, v[3:0]} : 9'd1;
                end else if (k.k3) rom_sel = (v[6:0] != 7'd0) ? {2'd0, v[6:0]} : 9'd1;
                else if (a < 16'h3000) rom_sel = {rom_sel[8], v};
                else rom_sel = {v[0], rom_sel[7:0]};
            end else if (a < 16'h6000) begin
                if (k.k1) begin
                    bank_hi = v[1:0];
                    ram_sel = {6'd0, v[1:0]};
                end else if (k.k3) ram_sel = v;
                else if (k.k5) ram_sel = {4'd0, v[3:0]};
            end else if (a < 16'h8000) begin
                if (k.k1) mode = v[0];
                else if (k.k3) begin
                    if (!latch_prev_one && v == 8'd1) rtc_latched = rtc;
                    latch_prev_one = (v == 8'd1);
                end
            end else if (ram_win && ram_on) begin
                if (k.k2) begin
                    nibbles[a[8:0]] = v[3:0];
                    if (k.batt) dirty = 1'b1;
                end else if (k.k3 && ram_sel >= 8'h08 && ram_sel <= 8'h0C) begin
                    rtc[ram_sel[2:0]] = v;
                end else if (!k.k3 || ram_sel <= 8'h03) begin
                    bank = ext_ram_bank(k);
                    if (bank >= 0) begin
                        r.target = TGT_RAM;
                        r.phys_address = 23'(bank * 'h2000 + int'(a) - 'hA000);
                        if (k.batt) dirty = 1'b1;
                    end
                end
            end
        end else if (req == REQ_TICK) begin
            advance_second();
        end
        r.save_needed = dirty;
    endtask

    assign o_pending = answer_q.size();

    always @(posedge i_clk) begin
        bus_answer_t want, got;
        if (!i_rst_n) begin
            kind_code = 8'd0;
            ram_code = 3'd0;
            bank_count = 10'd2;
            ram_on = 1'b0;
            bank_lo = 5'd1;
            bank_hi = 2'd0;
            rom_sel = 9'd1;
            ram_sel = 8'd0;
            mode = 1'b0;
            foreach (nibbles[i]) nibbles[i] = 4'd0;
            foreach (rtc[i]) begin
                rtc[i] = 8'd0;
                rtc_latched[i] = 8'd0;
            end
            latch_prev_one = 1'b0;
            dirty = 1'b0;
            answer_q.delete();
            o_failures = 0;
            o_results = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KIND:  kind_code = i_cfg_data[7:0];
                    CFG_RSIZE: ram_code = i_cfg_data[2:0];
                    CFG_RBCNT: bank_count = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_target, i_phys_address, i_read_data, i_save_needed};
                o_results++;
                if (answer_q.size() == 0) begin
                    $display("%0t: result with nothing expected: %h", $time, got);
                    o_failures++;
                end else begin
                    want = answer_q.pop_front();
                    if (want.target !== got.target) begin
                        $display("%0t: target expected %0d got %0d",
                                 $time, want.target, got.target);
                        o_failures++;
                    end
                    if (want.phys_address !== got.phys_address) begin
                        $display("%0t: phys_address expected %h got %h",
                                 $time, want.phys_address, got.phys_address);
                        o_failures++;
                    end
                    if (want.read_data !== got.read_data) begin
                        $display("%0t: read_data expected %h got %h",
                                 $time, want.read_data, got.read_data);
                        o_failures++;
                    end
                    if (want.save_needed !== got.save_needed) begin
                        $display("%0t: save_needed expected %b got %b",
                                 $time, want.save_needed, got.save_needed);
                        o_failures++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_access(i_req_type, i_bus_address, i_write_value, want);
                answer_q.push_back(want);
            end
        end
    end

endmodule

### tb/cartridge_bank_controller_top_test.sv
// top of the cartridge bank controller testbench: stimulus, handshakes and verdict
module cartridge_bank_controller_top_test;
    import cbc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEMS_PER_PHASE = 96;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type = REQ_READ;
    logic [15:0] i_bus_address = '0;
    logic [7:0]  i_write_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_target;
    logic [22:0] o_phys_address;
    logic [7:0]  o_read_data;
    logic        o_save_needed;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_KIND;
    logic [9:0]  i_cfg_data = '0;

    int  pending, failures, results;
    int  cycles = 0;
    int  items_sent = 0;
    bit  steady = 1'b0;

    cartridge_bank_controller_top dut (.*);

    cartridge_bank_controller_checker checker_i (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_ready(o_in_ready),
        .i_req_type, .i_bus_address, .i_write_value,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_target(o_target), .i_phys_address(o_phys_address),
        .i_read_data(o_read_data), .i_save_needed(o_save_needed),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_pending(pending), .o_failures(failures), .o_results(results)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 19);
    end

    task automatic send_item(input logic [1:0] req, input logic [15:0] a,
                             input logic [7:0] v);
        if (!steady && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_bus_address <= a;
        i_write_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // lower valid, then wait for every result and for the back end to settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic setup(input logic [7:0] kind, input logic [2:0] rsize,
                         input logic [9:0] banks);
        write_reg(CFG_KIND, {2'b0, kind});
        write_reg(CFG_RSIZE, {7'b0, rsize});
        write_reg(CFG_RBCNT, banks);
    endtask

    // values that hit clock rollovers, halt and the day carry
    function automatic logic [7:0] clock_value();
        case ($urandom_range(7))
            0: return 8'd59;
            1: return 8'd23;
            2: return 8'hFF;
            3: return 8'h40;
            4: return 8'h01;
            5: return 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic random_item();
        int r;
        logic [15:0] a;
        logic [7:0]  v;
        r = $urandom_range(99);
        v = 8'($urandom_range(255));
        if (r < 12) begin
            send_item(REQ_TICK, 16'($urandom_range(65535)), v);
        end else if (r < 20) begin
            send_item(REQ_WRITE, 16'($urandom_range(16'h1FFF)),
                      ($urandom_range(3) != 0) ? 8'h0A : v);
        end else if (r < 30) begin
            send_item(REQ_WRITE, 16'($urandom_range(16'h2000, 16'h3FFF)), v);
        end else if (r < 38) begin
            if ($urandom_range(3) != 0)
                v = ($urandom_range(1) != 0) ? 8'($urandom_range(3))
                                             : 8'($urandom_range(8, 12));
            send_item(REQ_WRITE, 16'($urandom_range(16'h4000, 16'h5FFF)), v);
        end else if (r < 44) begin
            if ($urandom_range(3) != 0) v = 8'($urandom_range(1));
            send_item(REQ_WRITE, 16'($urandom_range(16'h6000, 16'h7FFF)), v);
        end else if (r < 58) begin
            send_item(REQ_WRITE, 16'($urandom_range(16'hA000, 16'hBFFF)), clock_value());
        end else if (r < 92) begin
            case ($urandom_range(2))
                0: a = 16'($urandom_range(16'h3FFF));
                1: a = 16'($urandom_range(16'h4000, 16'h7FFF));
                default: a = 16'($urandom_range(16'hA000, 16'hBFFF));
            endcase
            send_item(REQ_READ, a, v);
        end else begin
            send_item($urandom_range(1) ? REQ_WRITE : REQ_READ,
                      16'($urandom_range(65535)), v);
        end
    endtask

    task automatic random_phase(input logic [7:0] kind, input logic [2:0] rsize,
                                input logic [9:0] banks, input bit calm);
        drain();
        setup(kind, rsize, banks);
        steady = calm;
        for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            random_item();
            // one mid-phase hold until the block has answered everything
            if (i == ITEMS_PER_PHASE / 2 && kind == 8'h13) drain();
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: mbc1 with battery, four ram banks, largest rom
        setup(8'h03, 3'd3, 10'd512);
        send_item(REQ_READ,  16'h0000, 8'h00);
        send_item(REQ_READ,  16'h3FFF, 8'hFF);
        send_item(REQ_READ,  16'h4000, 8'h00);
        send_item(REQ_READ,  16'h7FFF, 8'h00);
        send_item(REQ_READ,  16'hA000, 8'h00);
        send_item(REQ_WRITE, 16'h0000, 8'h0A);
        send_item(REQ_WRITE, 16'h2000, 8'h00);
        send_item(REQ_READ,  16'h4000, 8'h00);
        send_item(REQ_WRITE, 16'h3FFF, 8'hFF);
        send_item(REQ_WRITE, 16'h4000, 8'h03);
        send_item(REQ_READ,  16'h5ABC, 8'h00);
        send_item(REQ_WRITE, 16'h6000, 8'h01);
        send_item(REQ_READ,  16'h1234, 8'h00);
        send_item(REQ_READ,  16'hBFFF, 8'h00);
        send_item(REQ_WRITE, 16'hA555, 8'hFF);
        send_item(REQ_READ,  16'hC000, 8'h00);
        send_item(REQ_READ,  16'hFFFF, 8'h00);
        send_item(REQ_WRITE, 16'hFFFF, 8'h55);
        send_item(REQ_WRITE, 16'h8000, 8'hAA);
        send_item(REQ_TICK,  16'h0000, 8'h00);
        send_item(REQ_WRITE, 16'h1FFF, 8'h00);
        send_item(REQ_READ,  16'hA000, 8'h00);

        random_phase(8'h03, 3'd3, 10'd512, 1'b0);
        random_phase(8'h01, 3'd5, 10'd1,   1'b1);
        random_phase(8'h02, 3'd0, 10'd37,  1'b0);
        random_phase(8'h05, 3'd0, 10'd16,  1'b0);
        random_phase(8'h06, 3'd1, 10'd3,   1'b0);
        random_phase(8'h0F, 3'd3, 10'd128, 1'b0);
        random_phase(8'h10, 3'd4, 10'd100, 1'b0);
        random_phase(8'h13, 3'd2, 10'd511, 1'b0);
        random_phase(8'h11, 3'd5, 10'd2,   1'b0);
        random_phase(8'h19, 3'd4, 10'd512, 1'b0);
        random_phase(8'h1B, 3'd5, 10'd300, 1'b0);
        random_phase(8'h1E, 3'd2, 10'($urandom_range(1, 511)), 1'b0);
        random_phase(8'h00, 3'd3, 10'd4,   1'b0);
        random_phase(8'hFF, 3'd4, 10'($urandom_range(1, 512)), 1'b0);
        drain();

        $display("covered %0d items over fourteen settings of kind, ram size and rom banks",
                 items_sent);
        $display("none, mbc1, mbc2, mbc3 clock and mbc5 mapping; %0d results compared",
                 results);
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
